@@ hdl/assert_macros.svh @@
// Assertion macros shared by the fractional delay line RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check: whenever ante holds at a clock edge, cons holds as well.
`define FDL_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("fdl assertion failed");

// Never check: cond must not hold at any clock edge outside reset.
`define FDL_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) !(cond)) \
    else $error("fdl assertion failed");

`endif

@@ hdl/fdl_pkg.sv @@
// Package for the fractional delay line: sizes, fixed-point constants,
// register codes and the structs passed between the front, queue and back.
package fdl_pkg;

  // Sizes of the store and of the sample and coefficient words.
  localparam int DELAY_DEPTH    = 4096;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_W         = 24;
  localparam int COEF_FRAC_BITS = 22;
  localparam int LEN_W          = 13;
  localparam int CFG_DATA_W     = 24;
  localparam int CFG_IDX_W      = 3;

  // Store addressing and length comparison widths.
  localparam int ADDR_W    = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int CNT_W     = $clog2(DELAY_DEPTH + 1);
  localparam int LEN_CMP_W = (LEN_W > CNT_W) ? LEN_W : CNT_W;

  // Biquad datapath widths: products, five-term accumulator, shifted result.
  localparam int PROD_W = SAMPLE_BITS + COEF_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int RES_W  = ACC_W - COEF_FRAC_BITS;

  // Queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Rounding constant and saturation limits.
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [RES_W-1:0] RES_MAX  =
    RES_W'({1'b0, {(SAMPLE_BITS - 1){1'b1}}});
  localparam logic signed [RES_W-1:0] RES_MIN  = -RES_MAX - RES_W'(1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coef_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH   = 3'd0,
    REG_ALLPASS_ENABLE = 3'd1,
    REG_COEF_B0        = 3'd2,
    REG_COEF_B1        = 3'd3,
    REG_COEF_B2        = 3'd4,
    REG_COEF_A1        = 3'd5,
    REG_COEF_A2        = 3'd6
  } cfg_reg_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [LEN_W-1:0] delay_length;
    logic             allpass_enable;
    coef_t            coef_b0;
    coef_t            coef_b1;
    coef_t            coef_b2;
    coef_t            coef_a1;
    coef_t            coef_a2;
  } cfg_t;

  // One sample beat moving between modules.
  typedef struct packed {
    logic    valid;
    sample_t sample;
  } fdl_beat_t;

endpackage

@@ hdl/fdl_ram.sv @@
// Generic single-port RAM with registered, read-first output.
// No dependencies; used for the delay store.
module fdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r <= mem_r[addr];
      if (we) begin
        mem_r[addr] <= wdata;
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/fdl_front.sv @@
// Front of the fractional delay line: circular delay store access and position.
// Depends on fdl_pkg and instantiates fdl_ram.
module fdl_front
  import fdl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_take,
  input  sample_t   in_sample,
  output fdl_beat_t push
);

  logic [LEN_CMP_W-1:0] len_ext;
  logic [LEN_CMP_W-1:0] len_eff;
  logic [LEN_CMP_W-1:0] pos_inc;
  logic [ADDR_W-1:0]    pos_eff;
  logic [ADDR_W-1:0]    pos_next;
  logic                 use_store;
  logic                 hit;
  logic                 ram_en;
  logic [SAMPLE_BITS-1:0] rdata;

  logic [ADDR_W-1:0] pos_r,  pos_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              vld_r,  vld_nxt;
  logic              use_r;
  logic              hit_r;
  sample_t           x_r;

  // Effective length: clamped to the store depth, zero means bypass.
  always_comb begin
    len_ext   = LEN_CMP_W'(cfg.delay_length);
    len_eff   = (len_ext > LEN_CMP_W'(DELAY_DEPTH)) ? LEN_CMP_W'(DELAY_DEPTH) : len_ext;
    use_store = (len_eff != '0);
  end

  // Position: restart at zero when the length no longer exceeds it, wrap after use.
  always_comb begin
    pos_eff  = (LEN_CMP_W'(pos_r) >= len_eff) ? '0 : pos_r;
    pos_inc  = LEN_CMP_W'(pos_eff) + LEN_CMP_W'(1);
    pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[ADDR_W-1:0];
  end

  // Entries are written as a growing prefix, so a fill count marks what is valid.
  assign hit    = (CNT_W'(pos_eff) < fill_r);
  assign ram_en = in_take && use_store;

  always_comb begin
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    vld_nxt  = in_take;
    if (ram_en) begin
      pos_nxt = pos_next;
      if (!hit) begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end
  end

  fdl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DELAY_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_en),
    .addr  (pos_eff),
    .wdata (in_sample),
    .rdata (rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
      vld_r  <= vld_nxt;
    end
  end

  // Payload that travels with the read.
  always_ff @(posedge clk) begin
    if (in_take) begin
      use_r <= use_store;
      hit_r <= hit;
      x_r   <= in_sample;
    end
  end

  // Delayed sample, zero for an entry never written, or the input on bypass.
  always_comb begin
    push.valid  = vld_r;
    push.sample = use_r ? (hit_r ? sample_t'(rdata) : '0) : x_r;
  end

endmodule

@@ hdl/fdl_queue.sv @@
// Short queue that decouples the delay front from the biquad back.
// Depends on fdl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fdl_queue
  import fdl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  fdl_beat_t          push,
  input  logic               pop,
  output fdl_beat_t          head,
  output logic [Q_CNT_W-1:0] count
);

  sample_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r,    cnt_nxt;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push.valid) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.sample;
    end
  end

  always_comb begin
    head.valid  = (cnt_r != '0);
    head.sample = mem_r[rd_ptr_r];
  end

  assign count = cnt_r;

  // The input credit check must keep the queue from overflowing.
  `FDL_ASSERT_NEVER(a_no_overflow, clk, rst_n, push.valid && !pop && cnt_r == Q_CNT_W'(Q_DEPTH))
  // The back must only take a beat that is present.
  `FDL_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && cnt_r == '0)

endmodule

@@ hdl/fdl_back.sv @@
// Back of the fractional delay line: direct form I allpass biquad with rounding,
// saturation and the output register. Depends on fdl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fdl_back
  import fdl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  fdl_beat_t head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output sample_t   out_sample,
  output logic      out_clip
);

  logic adv;
  logic fire3;

  // Stage 1: feedforward products and input history.
  logic                     v1_r;
  logic signed [PROD_W-1:0] pb0_r, pb1_r, pb2_r;
  sample_t                  xs1_r;
  sample_t                  x1_r, x2_r;

  // Stage 2: feedforward sum with the rounding constant folded in.
  logic                     v2_r;
  logic signed [ACC_W-1:0]  p_r, p_nxt;
  sample_t                  xs2_r;

  // Stage 3: feedback, rounding and saturation.
  logic signed [PROD_W-1:0] a1y;
  logic signed [PROD_W-1:0] a2p_r, a2p_nxt;
  sample_t                  a2_src;
  logic signed [ACC_W-1:0]  acc;
  logic signed [RES_W-1:0]  res;
  sample_t                  sat;
  logic                     sat_hit;
  sample_t                  y1_r, y2_r;
  sample_t                  y_sel;
  logic                     clip_sel;

  logic    out_valid_r;
  sample_t out_sample_r;
  logic    out_clip_r;

  // The whole back moves together unless a finished result is held.
  assign adv   = !out_valid_r || !out_stall;
  assign pop   = head.valid && adv;
  assign fire3 = v2_r && adv;

  // Stage 1 registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      pb0_r <= PROD_W'(cfg.coef_b0) * PROD_W'(head.sample);
      pb1_r <= PROD_W'(cfg.coef_b1) * PROD_W'(x1_r);
      pb2_r <= PROD_W'(cfg.coef_b2) * PROD_W'(x2_r);
      xs1_r <= head.sample;
    end
  end

  // Input history advances only for filtered samples.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
    end else if (pop && cfg.allpass_enable) begin
      x1_r <= head.sample;
      x2_r <= x1_r;
    end
  end

  // Stage 2 sum.
  assign p_nxt = ACC_W'(pb0_r) + ACC_W'(pb1_r) + ACC_W'(pb2_r) + ACC_HALF;

  always_ff @(posedge clk) begin
    if (adv && v1_r) begin
      p_r   <= p_nxt;
      xs2_r <= xs1_r;
    end
  end

  // The a2 term for the next sample is registered ahead of time from the
  // history value that will be its second previous output.
  always_comb begin
    a2_src  = (fire3 && cfg.allpass_enable) ? y1_r : y2_r;
    a2p_nxt = PROD_W'(cfg.coef_a2) * PROD_W'(a2_src);
  end

  // Feedback closes here: one product, the sum, rounding and saturation.
  always_comb begin
    a1y     = PROD_W'(cfg.coef_a1) * PROD_W'(y1_r);
    acc     = p_r - ACC_W'(a2p_r) - ACC_W'(a1y);
    res     = RES_W'(acc >>> COEF_FRAC_BITS);
    sat_hit = 1'b0;
    if (res > RES_MAX) begin
      sat     = sample_t'(RES_MAX);
      sat_hit = 1'b1;
    end else if (res < RES_MIN) begin
      sat     = sample_t'(RES_MIN);
      sat_hit = 1'b1;
    end else begin
      sat = sample_t'(res);
    end
    y_sel    = cfg.allpass_enable ? sat : xs2_r;
    clip_sel = cfg.allpass_enable && sat_hit;
  end

  // Output history and the precomputed a2 term.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y1_r  <= '0;
      y2_r  <= '0;
      a2p_r <= '0;
    end else begin
      a2p_r <= a2p_nxt;
      if (fire3 && cfg.allpass_enable) begin
        y1_r <= sat;
        y2_r <= y1_r;
      end
    end
  end

  // Stage valid flags and output beat control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= pop;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire3) begin
      out_sample_r <= y_sel;
      out_clip_r   <= clip_sel;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_clip   = out_clip_r;

  // Saturation is only reported for samples that went through the biquad.
  `FDL_ASSERT_IMP(a_clip_needs_allpass, clk, rst_n, out_valid_r && out_clip_r,
                  cfg.allpass_enable)

endmodule

@@ hdl/fractional_delay_line.sv @@
// Fractional delay line: an integer delay through a circular store of
// DELAY_DEPTH samples, followed by an optional allpass biquad (Q2.22
// coefficients) that supplies the fractional part of the delay. It takes one
// sample per cycle while the output is not stalled and gives one result per
// sample, in order. When nothing waits, a sample goes through the store
// access, the queue between the store and the filter, and the product and sum
// stages of the biquad, whose third stage is the output register. The
// sustained rate of one sample per cycle is set by the filter's feedback path,
// which closes combinationally around one multiplier, the accumulator sum,
// rounding and saturation. The store needs no clearing pass after reset;
// entries never written read as zero.
// Depends on fdl_pkg, fdl_front, fdl_queue and fdl_back.
module fractional_delay_line
  import fdl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input sample channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sample_t               in_sample_in,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output sample_t               out_sample_out,
  output logic                  out_clipped,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg_r, cfg_nxt;
  logic      rdy_r;
  logic      in_take;
  fdl_beat_t push;
  fdl_beat_t head;
  logic      pop;
  logic [Q_CNT_W-1:0] q_count;
  logic [Q_CNT_W:0]   credit_used;

  // Configuration register decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DELAY_LENGTH:   cfg_nxt.delay_length   = cfg_data[LEN_W-1:0];
        REG_ALLPASS_ENABLE: cfg_nxt.allpass_enable = cfg_data[0];
        REG_COEF_B0:        cfg_nxt.coef_b0        = coef_t'(cfg_data[COEF_W-1:0]);
        REG_COEF_B1:        cfg_nxt.coef_b1        = coef_t'(cfg_data[COEF_W-1:0]);
        REG_COEF_B2:        cfg_nxt.coef_b2        = coef_t'(cfg_data[COEF_W-1:0]);
        REG_COEF_A1:        cfg_nxt.coef_a1        = coef_t'(cfg_data[COEF_W-1:0]);
        REG_COEF_A2:        cfg_nxt.coef_a2        = coef_t'(cfg_data[COEF_W-1:0]);
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
      rdy_r <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      rdy_r <= 1'b1;
    end
  end

  // Accept a beat only when the queue has room for it and the one in flight.
  assign credit_used = (Q_CNT_W + 1)'(q_count) + (Q_CNT_W + 1)'(push.valid);
  assign in_stall    = !rdy_r || (credit_used >= (Q_CNT_W + 1)'(Q_DEPTH - 1));
  assign in_take     = in_valid && !in_stall;

  fdl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_take   (in_take),
    .in_sample (in_sample_in),
    .push      (push)
  );

  fdl_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  fdl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample_out),
    .out_clip   (out_clipped)
  );

endmodule
